// ===== rtl/core/svpc_pkg.sv =====
// Shared types, constants and reset values for the servo PWM position controller.
package svpc_pkg;

  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned TRAVEL_W = 20;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_PWM_TICK = 2'd1;
  localparam logic [1:0] CMD_TRAVEL_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_ENABLE = 3'd5;

  localparam logic [PULSE_W-1:0] PWM_PERIOD_RST = 16'd20000;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd680;
  localparam logic [PULSE_W-1:0] MID_PULSE_RST = 16'd1400;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2300;
  localparam logic [TRAVEL_W-1:0] SWEEP_TIME_RST = 20'd61875;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 8'sd90;

  // floor(x/90) via offset: x + 90*2^16 is always positive
  localparam logic signed [25:0] DIV90_BIAS = 26'sd5898240;
  localparam int unsigned DIV90_SHIFT = 31;
  localparam logic [24:0] RECIP90 = 25'(((64'd1 << DIV90_SHIFT) + 64'd89) / 64'd90);
  localparam int unsigned DIV180_SHIFT = 36;
  localparam logic [28:0] RECIP180 = 29'(((64'd1 << DIV180_SHIFT) + 64'd179) / 64'd180);

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [ANGLE_W-1:0] target_angle;
  } svpc_in_t;

  typedef struct packed {
    logic               pwm_out;
    logic [PULSE_W-1:0] pulse_width;
    logic               reached;
    logic               moving;
  } svpc_out_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pwm_period;
    logic [PULSE_W-1:0]  min_pulse;
    logic [PULSE_W-1:0]  mid_pulse;
    logic [PULSE_W-1:0]  max_pulse;
    logic [TRAVEL_W-1:0] sweep_time;
    logic                notify_enable;
  } svpc_cfg_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                same;
    logic [PULSE_W-1:0]  duty;
    logic [TRAVEL_W-1:0] ticks;
  } svpc_op_t;

endpackage

// ===== rtl/core/svpc_front.sv =====
// Front pipeline: accepts items, clamps angles and precomputes pulse width and travel ticks.
module svpc_front import svpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  svpc_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  svpc_in_t   in_data_i,
  output logic       op_valid_o,
  input  logic       op_ready_i,
  output svpc_op_t   op_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic in_fire;

  logic signed [ANGLE_W-1:0] cur_angle_q, cur_angle_d;
  logic signed [ANGLE_W-1:0] angle_c;
  logic signed [ANGLE_W:0]   delta_c;
  logic [ANGLE_W-1:0]        mag_c;
  logic signed [PULSE_W:0]   span_c;

  logic [1:0]                s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic                      s1_same_q, s2_same_q, s3_same_q;
  logic signed [ANGLE_W-1:0] s1_angle_q;
  logic signed [PULSE_W:0]   s1_span_q;
  logic [ANGLE_W-1:0]        s1_mag_q;

  logic signed [25:0] prod1_c;
  logic [27:0]        prod2_c;
  logic [23:0]        s2_x1_q;
  logic [27:0]        s2_x2_q;

  logic [55:0]         m1_c;
  logic [63:0]         m2_c;
  logic [16:0]         s3_q1_q;
  logic [TRAVEL_W-1:0] s3_q2_q;

  logic signed [18:0]  width_c;
  logic [PULSE_W-1:0]  duty_c;

  assign en3 = !v3_q || op_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_fire = in_valid_i && en1;

  always_comb begin
    if (in_data_i.target_angle < -ANGLE_LIMIT) begin
      angle_c = -ANGLE_LIMIT;
    end else if (in_data_i.target_angle > ANGLE_LIMIT) begin
      angle_c = ANGLE_LIMIT;
    end else begin
      angle_c = in_data_i.target_angle;
    end
    delta_c = (ANGLE_W+1)'(angle_c) - (ANGLE_W+1)'(cur_angle_q);
    mag_c = delta_c[ANGLE_W] ? ANGLE_W'(-delta_c) : delta_c[ANGLE_W-1:0];
    if (angle_c[ANGLE_W-1]) begin
      span_c = $signed({1'b0, cfg_i.mid_pulse}) - $signed({1'b0, cfg_i.min_pulse});
    end else begin
      span_c = $signed({1'b0, cfg_i.max_pulse}) - $signed({1'b0, cfg_i.mid_pulse});
    end
  end

  // the current angle after any set is always the clamped target
  assign cur_angle_d = (in_fire && in_data_i.cmd == CMD_SET) ? angle_c : cur_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      cur_angle_q <= '0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      cur_angle_q <= cur_angle_d;
    end
  end

  assign prod1_c = 26'(s1_angle_q) * 26'(s1_span_q) + DIV90_BIAS;
  assign prod2_c = 28'(s1_mag_q) * 28'(cfg_i.sweep_time);
  assign m1_c = 56'(s2_x1_q) * 56'(RECIP90);
  assign m2_c = 64'(s2_x2_q) * 64'(RECIP180);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_cmd_q   <= in_data_i.cmd;
      s1_same_q  <= (angle_c == cur_angle_q);
      s1_angle_q <= angle_c;
      s1_span_q  <= span_c;
      s1_mag_q   <= mag_c;
    end
    if (en2) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_same_q <= s1_same_q;
      s2_x1_q   <= prod1_c[23:0];
      s2_x2_q   <= prod2_c;
    end
    if (en3) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_same_q <= s2_same_q;
      s3_q1_q   <= m1_c[DIV90_SHIFT+16:DIV90_SHIFT];
      s3_q2_q   <= m2_c[DIV180_SHIFT+TRAVEL_W-1:DIV180_SHIFT];
    end
  end

  // undo the bias (65536 after division) and saturate
  always_comb begin
    width_c = $signed({3'b000, cfg_i.mid_pulse}) + $signed({2'b00, s3_q1_q})
              - 19'sd65536;
    if (width_c < 0) begin
      duty_c = '0;
    end else if (width_c > 19'sd65535) begin
      duty_c = '1;
    end else begin
      duty_c = width_c[PULSE_W-1:0];
    end
  end

  assign op_valid_o = v3_q;
  assign op_o.cmd   = s3_cmd_q;
  assign op_o.same  = s3_same_q;
  assign op_o.duty  = duty_c;
  assign op_o.ticks = s3_q2_q;

endmodule

// ===== rtl/core/svpc_fifo.sv =====
// Small flop-based queue between the front pipeline and the executing back end.
module svpc_fifo import svpc_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     ready_o,
  input  svpc_op_t data_i,
  input  logic     pop_i,
  output logic     valid_o,
  output svpc_op_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  svpc_op_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/core/svpc_back.sv =====
// Back end: holds PWM counter, duty and travel state, and registers each result.
module svpc_back import svpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  svpc_cfg_t cfg_i,
  input  logic      op_valid_i,
  output logic      op_pop_o,
  input  svpc_op_t  op_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output svpc_out_t out_data_o
);

  logic [PULSE_W-1:0]  cnt_q, cnt_d;
  logic [PULSE_W-1:0]  duty_q, duty_d;
  logic [TRAVEL_W-1:0] tcount_q, tcount_d;
  logic                active_q, active_d;
  logic                out_valid_q;
  svpc_out_t           out_q, res_c;
  logic                level;
  logic                reached;

  assign op_pop_o = op_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    cnt_d    = cnt_q;
    duty_d   = duty_q;
    tcount_d = tcount_q;
    active_d = active_q;
    reached  = 1'b0;
    level    = (cnt_q < duty_q);
    case (op_i.cmd)
      CMD_SET: begin
        duty_d = op_i.duty;
        cnt_d  = '0;
        level  = (op_i.duty != '0);
        if (op_i.same && cfg_i.notify_enable) begin
          reached = 1'b1;
        end else if (op_i.ticks == '0) begin
          tcount_d = '0;
          active_d = 1'b0;
          reached  = cfg_i.notify_enable;
        end else begin
          tcount_d = op_i.ticks;
          active_d = 1'b1;
        end
      end
      CMD_PWM_TICK: begin
        cnt_d = (cnt_q >= cfg_i.pwm_period) ? '0 : cnt_q + 1'b1;
      end
      CMD_TRAVEL_TICK: begin
        if (active_q) begin
          tcount_d = (tcount_q != '0) ? tcount_q - 1'b1 : tcount_q;
          if (tcount_d == '0) begin
            active_d = 1'b0;
            reached  = cfg_i.notify_enable;
          end
        end
      end
      default: begin
      end
    endcase
    res_c.pwm_out     = level;
    res_c.pulse_width = duty_d;
    res_c.reached     = reached;
    res_c.moving      = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      duty_q      <= MID_PULSE_RST;
      tcount_q    <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_pop_o) begin
        cnt_q    <= cnt_d;
        duty_q   <= duty_d;
        tcount_q <= tcount_d;
        active_q <= active_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) out_q <= res_c;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/servo_pwm_position_controller.sv =====
// Results are registered. Throughput: one transaction per cycle unless the output is
// stalled; the front pipeline (clamp, two multiply stages, saturation) runs ahead of
// the stateful back end through a short queue.
// Reset clears PWM counter, travel state and current angle; duty and registers
// take their documented defaults. No clearing pass.
module servo_pwm_position_controller import svpc_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  svpc_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output svpc_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  svpc_cfg_t cfg_q;
  svpc_op_t  fe_op, q_op;
  logic      fe_valid, q_ready, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period    <= PWM_PERIOD_RST;
      cfg_q.min_pulse     <= MIN_PULSE_RST;
      cfg_q.mid_pulse     <= MID_PULSE_RST;
      cfg_q.max_pulse     <= MAX_PULSE_RST;
      cfg_q.sweep_time    <= SWEEP_TIME_RST;
      cfg_q.notify_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_PERIOD:    cfg_q.pwm_period    <= cfg_data_i[PULSE_W-1:0];
        CFG_MIN_PULSE:     cfg_q.min_pulse     <= cfg_data_i[PULSE_W-1:0];
        CFG_MID_PULSE:     cfg_q.mid_pulse     <= cfg_data_i[PULSE_W-1:0];
        CFG_MAX_PULSE:     cfg_q.max_pulse     <= cfg_data_i[PULSE_W-1:0];
        CFG_SWEEP_TIME:    cfg_q.sweep_time    <= cfg_data_i[TRAVEL_W-1:0];
        CFG_NOTIFY_ENABLE: cfg_q.notify_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  svpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (fe_valid),
    .op_ready_i (q_ready),
    .op_o       (fe_op)
  );

  svpc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .ready_o (q_ready),
    .data_i  (fe_op),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_op)
  );

  svpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (q_valid),
    .op_pop_o    (q_pop),
    .op_i        (q_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the servo PWM position controller: directed and random transactions.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import svpc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DEG_LIMIT = 90;
  localparam int DEG_TURN = 180;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  svpc_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  svpc_out_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  servo_pwm_position_controller DUT (.*);

  // shadow copy of the block's registers and state
  svpc_cfg_t           shadow_cfg;
  int                  angle_now;
  logic [PULSE_W-1:0]  duty_now;
  logic [PULSE_W-1:0]  pwm_count_now;
  logic [TRAVEL_W-1:0] travel_left;
  logic                travel_running;
  svpc_out_t           servo_response_q[$];

  int unsigned accepted_items;
  int unsigned checked_items;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned n_set, n_pwm, n_travel, n_spare, n_reached, n_cfg;
  int          tx_mode, tx_mode_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("servo_pwm_position_controller verification failed");
      $finish;
    end
  end

  function automatic void reset_shadow();
    shadow_cfg.pwm_period    = PWM_PERIOD_RST;
    shadow_cfg.min_pulse     = MIN_PULSE_RST;
    shadow_cfg.mid_pulse     = MID_PULSE_RST;
    shadow_cfg.max_pulse     = MAX_PULSE_RST;
    shadow_cfg.sweep_time    = SWEEP_TIME_RST;
    shadow_cfg.notify_enable = 1'b0;
    angle_now      = 0;
    duty_now       = MID_PULSE_RST;
    pwm_count_now  = '0;
    travel_left    = '0;
    travel_running = 1'b0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PWM_PERIOD:    shadow_cfg.pwm_period = data[PULSE_W-1:0];
      CFG_MIN_PULSE:     shadow_cfg.min_pulse = data[PULSE_W-1:0];
      CFG_MID_PULSE:     shadow_cfg.mid_pulse = data[PULSE_W-1:0];
      CFG_MAX_PULSE:     shadow_cfg.max_pulse = data[PULSE_W-1:0];
      CFG_SWEEP_TIME:    shadow_cfg.sweep_time = data[TRAVEL_W-1:0];
      CFG_NOTIFY_ENABLE: shadow_cfg.notify_enable = data[0];
      default: ;
    endcase
  endfunction

  // piecewise-linear angle to high time, floor division, clamped to 16 bits
  function automatic logic [PULSE_W-1:0] angle_to_width(int ang);
    longint span;
    longint prod;
    longint quot;
    longint width;
    if (ang < 0) begin
      span = longint'(shadow_cfg.mid_pulse) - longint'(shadow_cfg.min_pulse);
    end else begin
      span = longint'(shadow_cfg.max_pulse) - longint'(shadow_cfg.mid_pulse);
    end
    prod = longint'(ang) * span;
    quot = prod / DEG_LIMIT;
    if ((prod % DEG_LIMIT != 0) && (prod < 0)) quot = quot - 1;
    width = longint'(shadow_cfg.mid_pulse) + quot;
    if (width < 0) width = 0;
    if (width > 65535) width = 65535;
    return width[PULSE_W-1:0];
  endfunction

  function automatic svpc_out_t compute_servo_response(svpc_in_t item);
    svpc_out_t resp;
    int        ang;
    int        delta;
    longint    steps;
    logic      hit;
    hit = 1'b0;
    case (item.cmd)
      CMD_SET: begin
        ang = int'($signed(item.target_angle));
        if (ang < -DEG_LIMIT) ang = -DEG_LIMIT;
        if (ang > DEG_LIMIT) ang = DEG_LIMIT;
        duty_now = angle_to_width(ang);
        pwm_count_now = '0;
        if (ang == angle_now && shadow_cfg.notify_enable) begin
          hit = 1'b1;
        end else begin
          delta = (ang > angle_now) ? ang - angle_now : angle_now - ang;
          steps = (longint'(delta) * longint'(shadow_cfg.sweep_time)) / DEG_TURN;
          angle_now = ang;
          if (steps == 0) begin
            travel_left = '0;
            travel_running = 1'b0;
            hit = shadow_cfg.notify_enable;
          end else begin
            travel_left = steps[TRAVEL_W-1:0];
            travel_running = 1'b1;
          end
        end
        resp.pwm_out = (pwm_count_now < duty_now);
      end
      CMD_PWM_TICK: begin
        resp.pwm_out = (pwm_count_now < duty_now);
        if (pwm_count_now >= shadow_cfg.pwm_period) begin
          pwm_count_now = '0;
        end else begin
          pwm_count_now = pwm_count_now + 1'b1;
        end
      end
      default: begin
        if (item.cmd == CMD_TRAVEL_TICK && travel_running) begin
          if (travel_left != 0) travel_left = travel_left - 1'b1;
          if (travel_left == 0) begin
            travel_running = 1'b0;
            hit = shadow_cfg.notify_enable;
          end
        end
        resp.pwm_out = (pwm_count_now < duty_now);
      end
    endcase
    resp.pulse_width = duty_now;
    resp.reached = hit;
    resp.moving = travel_running;
    return resp;
  endfunction

  // results are checked first so a stray one is never paired with a fresh transaction
  always @(posedge clk_i) begin
    svpc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (servo_response_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result with no transaction pending: %p", $realtime, out_data_o);
        end else begin
          want = servo_response_q.pop_front();
          checked_items++;
          if (out_data_o.reached === 1'b1) n_reached++;
          if (out_data_o.pwm_out !== want.pwm_out ||
              out_data_o.pulse_width !== want.pulse_width ||
              out_data_o.reached !== want.reached ||
              out_data_o.moving !== want.moving) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] result %0d: expected pwm=%0b width=%0d reached=%0b moving=%0b",
                       $realtime, checked_items, want.pwm_out, want.pulse_width,
                       want.reached, want.moving);
              $display("    got pwm=%0b width=%0d reached=%0b moving=%0b",
                       out_data_o.pwm_out, out_data_o.pulse_width,
                       out_data_o.reached, out_data_o.moving);
            end
          end
        end
      end
      if (cfg_we_i) apply_register(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        servo_response_q.push_back(compute_servo_response(in_data_i));
        accepted_items++;
      end
    end
  end

  // receiver: modes of no stall, short stalls and occasional long stalls
  initial begin
    int   hold;
    int   mode_left;
    int   rx_mode;
    logic rdy;
    hold = 0;
    mode_left = 0;
    rx_mode = 0;
    rdy = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 150);
      end else begin
        mode_left--;
      end
      if (hold == 0) begin
        case (rx_mode)
          0: begin
            rdy = 1'b1;
          end
          1: begin
            rdy = ($urandom_range(0, 3) != 0);
            hold = $urandom_range(0, 2);
          end
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              rdy = 1'b0;
              hold = $urandom_range(8, 40);
            end else begin
              rdy = 1'b1;
              hold = $urandom_range(0, 5);
            end
          end
        endcase
      end else begin
        hold--;
      end
      out_ready_i <= rdy;
    end
  end

  function automatic int pick_gap();
    if (tx_mode_left == 0) begin
      tx_mode = $urandom_range(0, 2);
      tx_mode_left = $urandom_range(20, 80);
    end else begin
      tx_mode_left--;
    end
    case (tx_mode)
      0: return 0;
      1: return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 3)) : 0;
      default: return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 30))
                                                   : int'($urandom_range(0, 1));
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance and any gap
  task automatic send_item(logic [1:0] cmd, logic [ANGLE_W-1:0] angle);
    svpc_in_t    item;
    int unsigned seen_cnt;
    int          gap;
    item.cmd = cmd;
    item.target_angle = angle;
    seen_cnt = accepted_items;
    in_data_i <= item;
    in_valid_i <= 1'b1;
    case (cmd)
      CMD_SET:         n_set++;
      CMD_PWM_TICK:    n_pwm++;
      CMD_TRAVEL_TICK: n_travel++;
      default:         n_spare++;
    endcase
    do @(negedge clk_i); while (accepted_items == seen_cnt);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (servo_response_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    n_cfg++;
  endtask

  // unused data bits carry junk to check the masking
  task automatic load_config(logic [15:0] period, logic [15:0] minp, logic [15:0] midp,
                             logic [15:0] maxp, logic [19:0] sweep, logic notify);
    write_reg(CFG_PWM_PERIOD, {4'($urandom), period});
    write_reg(CFG_MIN_PULSE, {4'($urandom), minp});
    write_reg(CFG_MID_PULSE, {4'($urandom), midp});
    write_reg(CFG_MAX_PULSE, {4'($urandom), maxp});
    write_reg(CFG_SWEEP_TIME, sweep);
    write_reg(CFG_NOTIFY_ENABLE, {19'($urandom), notify});
  endtask

  task automatic test_reset_defaults();
    send_item(CMD_PWM_TICK, 8'h00);
    send_item(CMD_SET, 8'd0);        // same angle, notify off
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_SET, 8'd90);
    send_item(CMD_TRAVEL_TICK, 8'h00);
    wait_all_results();
  endtask

  task automatic test_angle_extremes();
    load_config(PWM_PERIOD_RST, MIN_PULSE_RST, MID_PULSE_RST, MAX_PULSE_RST, 20'd360, 1'b1);
    send_item(CMD_SET, 8'h80);       // -128 clamps to -90
    send_item(CMD_SET, 8'h7F);       // 127 clamps to 90
    send_item(CMD_SET, 8'd90);       // same angle, notify on: countdown untouched
    send_item(CMD_SET, 8'hA5);       // -91
    send_item(CMD_SET, 8'd91);
    send_item(CMD_SET, 8'd89);       // two travel ticks
    repeat (3) send_item(CMD_TRAVEL_TICK, 8'($urandom));
    wait_all_results();
  endtask

  task automatic test_pwm_wrap();
    write_reg(CFG_PWM_PERIOD, 20'd5);
    write_reg(CFG_MID_PULSE, 20'd2);
    send_item(CMD_SET, 8'd0);
    repeat (5) send_item(CMD_PWM_TICK, 8'($urandom));
    wait_all_results();
    write_reg(CFG_PWM_PERIOD, 20'd1);  // counter now above the period
    repeat (3) send_item(CMD_PWM_TICK, 8'($urandom));
    wait_all_results();
  endtask

  task automatic test_odd_pulses();
    load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 20'd1, 1'b1);
    write_reg(CFG_SPARE_LO, 20'($urandom));
    write_reg(CFG_SPARE_HI, 20'($urandom));
    send_item(CMD_SET, 8'hD3);       // -45, travel rounds to zero
    send_item(CMD_SET, 8'd45);
    send_item(CMD_UNUSED, 8'h00);
    wait_all_results();
  endtask

  task automatic run_bursts(int unsigned quota);
    int unsigned sent;
    int          tgt;
    int          burst;
    int          pick;
    logic [1:0]  op;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        tgt = $urandom_range(0, 255);
      end else if (pick == 1) begin
        tgt = angle_now;
      end else begin
        tgt = angle_now + int'($urandom_range(0, 20)) - 10;
        if (tgt < -DEG_LIMIT) tgt = -DEG_LIMIT;
        if (tgt > DEG_LIMIT) tgt = DEG_LIMIT;
      end
      send_item(CMD_SET, 8'(tgt));
      sent++;
      burst = $urandom_range(0, 14);
      for (int k = 0; k < burst && sent < quota; k++) begin
        pick = $urandom_range(0, 19);
        op = (pick < 9) ? CMD_PWM_TICK : (pick < 19) ? CMD_TRAVEL_TICK : CMD_UNUSED;
        send_item(op, 8'($urandom));
        sent++;
      end
      if ($urandom_range(0, 29) == 0) wait_all_results();
    end
  endtask

  task automatic pick_sweep(output logic [19:0] sweep);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) sweep = '0;
    else if (sel < 17) sweep = 20'($urandom_range(1, 360));
    else sweep = 20'($urandom);
  endtask

  task automatic test_random_phases();
    logic [15:0] period;
    logic [15:0] minp;
    logic [15:0] midp;
    logic [15:0] maxp;
    logic [19:0] sweep;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_config(16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 20'hFFFFF, 1'b1);
        1: load_config(16'h0001, 16'h0000, 16'h0000, 16'h0000, 20'h00000, 1'b0);
        default: begin
          period = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 40))
                                               : 16'($urandom_range(1, 65535));
          if ($urandom_range(0, 1) == 0) begin
            minp = 16'($urandom_range(0, 2000));
            midp = minp + 16'($urandom_range(0, 2000));
            maxp = midp + 16'($urandom_range(0, 2000));
          end else begin
            minp = 16'($urandom);
            midp = 16'($urandom);
            maxp = 16'($urandom);
          end
          pick_sweep(sweep);
          load_config(period, minp, midp, maxp, sweep, 1'($urandom));
        end
      endcase
      run_bursts(110);
      wait_all_results();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cycle_count = 0;
    accepted_items = 0;
    checked_items = 0;
    mismatches = 0;
    n_set = 0;
    n_pwm = 0;
    n_travel = 0;
    n_spare = 0;
    n_reached = 0;
    n_cfg = 0;
    tx_mode = 0;
    tx_mode_left = 0;
    reset_shadow();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_angle_extremes();
    test_pwm_wrap();
    test_odd_pulses();
    test_random_phases();
    wait_all_results();

    $display("Ran %0d set, %0d PWM tick, %0d travel tick, %0d spare-code transactions, %0d reg writes",
             n_set, n_pwm, n_travel, n_spare, n_cfg);
    $display("Checked %0d results (%0d with reached high), %0d mismatches",
             checked_items, n_reached, mismatches);
    if (mismatches == 0) begin
      $display("servo_pwm_position_controller verification clean");
    end else begin
      $display("servo_pwm_position_controller verification failed");
    end
    $finish;
  end

endmodule
